>>> hw/rtl/dpr_pkg.sv
// Shared package for the depth pixel reprojection block.
// Holds widths, register indexes, parameter defaults and controller types; no dependencies.
`default_nettype none
package dpr_pkg;
   localparam int MaxDimDefault = 4096;
   localparam int SkipDefault = 8;
   localparam int CsrAddrWidth = 5;
   localparam logic [13:0] DepthMask = 14'h3FFF;
   localparam int FracBits = 8;

   localparam logic [2:0] RegDepthWidth  = 3'd0;
   localparam logic [2:0] RegDepthHeight = 3'd1;
   localparam logic [2:0] RegCenterX     = 3'd2;
   localparam logic [2:0] RegCenterY     = 3'd3;
   localparam logic [2:0] RegInvFocalX   = 3'd4;
   localparam logic [2:0] RegInvFocalY   = 3'd5;
   localparam logic [2:0] RegColorWidth  = 3'd6;
   localparam logic [2:0] RegColorHeight = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL1 = 5'b00010,
      ST_MUL2 = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul1;
      logic mul2;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

>>> hw/rtl/depth_pixel_reprojection_unit.sv
// Top level of the depth pixel reprojection block.
// Depends on dpr_pkg, dpr_csr, dpr_ctrl and dpr_datapath.
// Usage: each req_ word carries one raw depth pixel in raster order; frame_start
// marks the first pixel of a frame. A pixel with nonzero depth outside the row 0
// watermark, and with both inverse focal lengths set, yields one rsp_ word with
// X and Y in Q.8 millimetres, Z in millimetres and colour indices rounded down.
// The block works on one word at a time: capture, the multiply states MUL1 and
// MUL2, then a restoring divider for the colour indexes that takes one quotient
// bit per cycle over 13 plus the bit count of MAX_DIM steps (26 by default)
// and a done step, then the output state. A new word is accepted only after the
// block has returned to idle, whether or not the last word yields a point.
// The result sits in an output register; the next word is accepted while an
// earlier result still waits for rsp_ready. A stalled receiver holds the block
// in its output state only when a second result is ready to load. Reset returns
// the position counters to column 0, row 0 and the registers to reset values.
// Registers must be written through csr_ while the block is idle (unenforced).
`default_nettype none
module depth_pixel_reprojection_unit import dpr_pkg::*; #(
   parameter int MAX_DIM = MaxDimDefault,
   parameter int SKIP_PIXELS = SkipDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [15:0]             req_depth_word,
   input  wire logic                    req_frame_start,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [24:0]           rsp_point_x,
   output logic signed [24:0]           rsp_point_y,
   output logic [13:0]                  rsp_point_z,
   output logic [11:0]                  rsp_color_col,
   output logic [11:0]                  rsp_color_row,
   output logic                         rsp_color_valid,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   cmd_type cmd;
   stat_type stat;
   logic [12:0] dw, dh, cw, ch;
   logic [19:0] cx, cy;
   logic [23:0] ifx, ify;

   assign csr_pready = 1'b1;

   dpr_csr u_csr (.clock, .reset, .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .dw, .dh, .cw, .ch, .cx, .cy, .ifx, .ify);

   dpr_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat);

   dpr_datapath #(.MAX_DIM(MAX_DIM), .SKIP_PIXELS(SKIP_PIXELS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .depth_word(req_depth_word), .frame_start(req_frame_start),
      .cfg_dw(dw), .cfg_dh(dh), .cfg_cx(cx), .cfg_cy(cy), .cfg_ifx(ifx), .cfg_ify(ify),
      .cfg_cw(cw), .cfg_ch(ch),
      .point_x(rsp_point_x), .point_y(rsp_point_y), .point_z(rsp_point_z),
      .color_col(rsp_color_col), .color_row(rsp_color_row),
      .color_valid(rsp_color_valid));
endmodule
`default_nettype wire

>>> hw/rtl/dpr_ctrl.sv
// Controller state machine of the depth pixel reprojection block.
// Depends on dpr_pkg; drives the datapath through cmd_type and reads stat_type.
`default_nettype none
module dpr_ctrl import dpr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.emit) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("result dropped");
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");
endmodule
`default_nettype wire

>>> hw/rtl/dpr_datapath.sv
// Datapath of the depth pixel reprojection block: counters, multipliers and divider.
// Depends on dpr_pkg; commanded by dpr_ctrl.
`default_nettype none
module dpr_datapath import dpr_pkg::*; #(
   parameter int MAX_DIM = MaxDimDefault,
   parameter int SKIP_PIXELS = SkipDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [15:0] depth_word,
   input  wire logic        frame_start,
   input  wire logic [12:0] cfg_dw,
   input  wire logic [12:0] cfg_dh,
   input  wire logic [19:0] cfg_cx,
   input  wire logic [19:0] cfg_cy,
   input  wire logic [23:0] cfg_ifx,
   input  wire logic [23:0] cfg_ify,
   input  wire logic [12:0] cfg_cw,
   input  wire logic [12:0] cfg_ch,
   output logic signed [24:0] point_x,
   output logic signed [24:0] point_y,
   output logic [13:0]      point_z,
   output logic [11:0]      color_col,
   output logic [11:0]      color_row,
   output logic             color_valid
);
   localparam int PW = $clog2(MAX_DIM + 1);
   localparam int CW = 13 + PW;
   localparam int NW = $clog2(CW + 1);

   logic [PW-1:0] col_ff, row_ff, w, h, ccol, crow, ncol, nrow;
   logic [PW-1:0] pcol_ff, prow_ff;
   logic [13:0] z_ff;
   logic emit_ff, cv_ff;
   logic [20:0] mx_ff, my_ff;
   logic negx_ff, negy_ff;
   logic [44:0] px_ff, py_ff;
   logic [58:0] qx_ff, qy_ff;
   logic [PW-1:0] remc_ff, remr_ff, divc_ff, divr_ff;
   logic [CW-1:0] qc_ff, qr_ff;
   logic [NW-1:0] cnt_ff;
   logic [PW:0] trc, trr;
   logic div_done;

   function automatic logic [PW-1:0] clampd(input logic [12:0] v);
      if (v == 13'd0) return PW'(1);
      if (32'(v) > MAX_DIM) return PW'(MAX_DIM);
      return PW'(v);
   endfunction

   function automatic logic [24:0] sat(input logic neg, input logic [58:0] p);
      logic [58:0] r;
      r = neg ? ((p + 59'hFFFFFF) >> 24) : (p >> 24);
      if (!neg) return (r > 59'd16777215) ? 25'h0FFFFFF : r[24:0];
      return (r > 59'd16777216) ? 25'h1000000 : (25'd0 - r[24:0]);
   endfunction

   always_comb begin
      w = clampd(cfg_dw);
      h = clampd(cfg_dh);
      ccol = frame_start ? '0 : col_ff;
      crow = frame_start ? '0 : row_ff;
      if (ccol >= w) begin
         ccol = '0;
         crow = crow + 1'b1;
      end
      if (crow >= h) crow = '0;
      ncol = ccol + 1'b1;
      nrow = crow;
      if (ncol >= w) begin
         ncol = '0;
         nrow = crow + 1'b1;
         if (nrow >= h) nrow = '0;
      end
   end

   logic signed [21:0] dx, dy;
   assign dx = $signed({1'b0, 21'(pcol_ff) << FracBits}) - $signed({2'b0, cfg_cx});
   assign dy = $signed({1'b0, 21'(prow_ff) << FracBits}) - $signed({2'b0, cfg_cy});

   assign trc = {remc_ff, qc_ff[CW-1]};
   assign trr = {remr_ff, qr_ff[CW-1]};
   assign div_done = (cnt_ff == NW'(CW));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.capture) begin
         col_ff <= ncol;
         row_ff <= nrow;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pcol_ff <= ccol;
         prow_ff <= crow;
         z_ff <= depth_word[13:0] & DepthMask;
         emit_ff <= (depth_word[13:0] != 14'd0) && (cfg_ifx != 24'd0) &&
                    (cfg_ify != 24'd0) && !(crow == '0 && 32'(ccol) < SKIP_PIXELS);
         cv_ff <= (cfg_cw != 13'd0) && (cfg_ch != 13'd0);
      end
      if (cmd.mul1) begin
         negx_ff <= dx[21];
         negy_ff <= dy[21];
         mx_ff <= dx[21] ? 21'(-dx) : dx[20:0];
         my_ff <= dy[21] ? 21'(-dy) : dy[20:0];
         qc_ff <= CW'(pcol_ff) * CW'(cfg_cw);
         qr_ff <= CW'(prow_ff) * CW'(cfg_ch);
         divc_ff <= w;
         divr_ff <= h;
         remc_ff <= '0;
         remr_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.mul2) begin
         px_ff <= 45'(mx_ff) * 45'(cfg_ifx);
         py_ff <= 45'(my_ff) * 45'(cfg_ify);
      end
      if (cmd.div_step && !div_done) begin
         if (cnt_ff == '0) begin
            qx_ff <= 59'(px_ff) * 59'(z_ff);
            qy_ff <= 59'(py_ff) * 59'(z_ff);
         end
         // Restoring division: one quotient bit per cycle, most significant first.
         if (trc >= {1'b0, divc_ff}) begin
            remc_ff <= PW'(trc - {1'b0, divc_ff});
            qc_ff <= {qc_ff[CW-2:0], 1'b1};
         end else begin
            remc_ff <= trc[PW-1:0];
            qc_ff <= {qc_ff[CW-2:0], 1'b0};
         end
         if (trr >= {1'b0, divr_ff}) begin
            remr_ff <= PW'(trr - {1'b0, divr_ff});
            qr_ff <= {qr_ff[CW-2:0], 1'b1};
         end else begin
            remr_ff <= trr[PW-1:0];
            qr_ff <= {qr_ff[CW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.load_out) begin
         point_x <= sat(negx_ff, qx_ff);
         point_y <= sat(negy_ff, qy_ff);
         point_z <= z_ff;
         color_col <= cv_ff ? ((qc_ff > CW'(4095)) ? 12'hFFF : qc_ff[11:0]) : 12'd0;
         color_row <= cv_ff ? ((qr_ff > CW'(4095)) ? 12'hFFF : qr_ff[11:0]) : 12'd0;
         color_valid <= cv_ff;
      end
   end

   assign stat.emit = emit_ff;
   assign stat.div_done = div_done;
endmodule
`default_nettype wire

>>> hw/rtl/dpr_csr.sv
// Configuration register file of the depth pixel reprojection block.
// Depends on dpr_pkg for register indexes and widths.
`default_nettype none
module dpr_csr import dpr_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic [12:0] dw, dh, cw, ch,
   output logic [19:0] cx, cy,
   output logic [23:0] ifx, ify
);
   logic [12:0] dw_ff, dh_ff, cw_ff, ch_ff;
   logic [19:0] cx_ff, cy_ff;
   logic [23:0] ifx_ff, ify_ff;
   logic [2:0] idx;
   assign idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff <= 13'd640; dh_ff <= 13'd480; cx_ff <= 20'd81920; cy_ff <= 20'd61440;
         ifx_ff <= '0; ify_ff <= '0; cw_ff <= '0; ch_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            RegDepthWidth:  dw_ff <= pwdata[12:0];
            RegDepthHeight: dh_ff <= pwdata[12:0];
            RegCenterX:     cx_ff <= pwdata[19:0];
            RegCenterY:     cy_ff <= pwdata[19:0];
            RegInvFocalX:   ifx_ff <= pwdata[23:0];
            RegInvFocalY:   ify_ff <= pwdata[23:0];
            RegColorWidth:  cw_ff <= pwdata[12:0];
            RegColorHeight: ch_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegDepthWidth:  prdata = 32'(dw_ff);
         RegDepthHeight: prdata = 32'(dh_ff);
         RegCenterX:     prdata = 32'(cx_ff);
         RegCenterY:     prdata = 32'(cy_ff);
         RegInvFocalX:   prdata = 32'(ifx_ff);
         RegInvFocalY:   prdata = 32'(ify_ff);
         RegColorWidth:  prdata = 32'(cw_ff);
         RegColorHeight: prdata = 32'(ch_ff);
         default:        prdata = '0;
      endcase
   end

   assign dw = dw_ff; assign dh = dh_ff; assign cw = cw_ff; assign ch = ch_ff;
   assign cx = cx_ff; assign cy = cy_ff; assign ifx = ifx_ff; assign ify = ify_ff;
endmodule
`default_nettype wire
